### src/rrqs_pkg.sv
// Shared constants, payload types and queue control types of the round-robin scheduler.
package rrqs_pkg;

  // Number of task slots and the widths that follow from it.
  localparam int MAX_TASKS = 64;
  localparam int IDX_W     = $clog2(MAX_TASKS);
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  // Fixed field widths.
  localparam int TASK_W = 6;
  localparam int QT_W   = 6;

  // Input event codes.
  localparam logic [1:0] MODE_ADMIT = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_EXIT  = 2'd2;

  // Result action codes.
  localparam logic [1:0] ACT_STOP   = 2'd0;
  localparam logic [1:0] ACT_FIRST  = 2'd1;
  localparam logic [1:0] ACT_RESUME = 2'd2;
  localparam logic [1:0] ACT_REJECT = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic [TASK_W-1:0] task_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [TASK_W-1:0] target_task;
    logic              last;
  } out_item_t;

  // Requests from the sequencer to the ready queue.
  typedef struct packed {
    logic              push;
    logic              pop;
    logic [TASK_W-1:0] push_slot;
  } fifo_cmd_t;

  // Ready queue status; pop_slot is valid the cycle after a pop.
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [TASK_W-1:0] pop_slot;
  } fifo_stat_t;

endpackage

### src/rrqs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module rrqs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, and read port that holds its data until the next read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/rrqs_fifo.sv
// Ready queue of task slots: head, tail and fill count around a RAM.
module rrqs_fifo
  import rrqs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  fifo_cmd_t  cmd,
  output fifo_stat_t stat
);

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r,  cnt_nxt;
  logic [TASK_W-1:0] rd_slot;

  // Pointer and count updates; a push and a pop in one cycle leave the count alone.
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (cmd.pop) begin
      head_nxt = (head_r == IDX_W'(MAX_TASKS - 1)) ? '0 : head_r + 1'b1;
    end
    if (cmd.push) begin
      tail_nxt = (tail_r == IDX_W'(MAX_TASKS - 1)) ? '0 : tail_r + 1'b1;
    end
    unique case ({cmd.push, cmd.pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Slot storage; a read and a write at one address return the old entry.
  rrqs_ram #(
    .WIDTH (TASK_W),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (tail_r),
    .wdata (cmd.push_slot),
    .re    (cmd.pop),
    .raddr (head_r),
    .rdata (rd_slot)
  );

  // Status: full, empty and the slot read by the last pop.
  assign stat = {(cnt_r == CNT_W'(MAX_TASKS)), (cnt_r == '0), rd_slot};

  // The sequencer never pops an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (cnt_r != '0))
    else $error("ready queue popped while empty");

  // A lone push never goes into a full queue.
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push && !cmd.pop) |-> (cnt_r != CNT_W'(MAX_TASKS)))
    else $error("ready queue pushed while full");

endmodule

### src/rrqs_ctrl.sv
// Scheduling sequencer: task flags, running task, quantum count and dispatch search.
module rrqs_ctrl
  import rrqs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  input  logic [QT_W-1:0]  quantum,
  output fifo_cmd_t        fifo_cmd,
  input  fifo_stat_t       fifo_stat,
  output logic             res_valid,
  input  logic             res_ready,
  output out_item_t        res_item
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POP   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_STOP  = 3'd3;
  localparam logic [2:0] S_DISP  = 3'd4;
  localparam logic [2:0] S_REJ   = 3'd5;

  logic [2:0]           state_r,     state_nxt;
  logic [MAX_TASKS-1:0] alive_r,     alive_nxt;
  logic [MAX_TASKS-1:0] ns_r,        ns_nxt;
  logic [IDX_W-1:0]     run_task_r,  run_task_nxt;
  logic                 run_valid_r, run_valid_nxt;
  logic [QT_W-1:0]      ticks_r,     ticks_nxt;
  logic                 stop_pend_r, stop_pend_nxt;
  logic                 found_r,     found_nxt;
  logic                 have_pop_r,  have_pop_nxt;
  logic [TASK_W-1:0]    stop_task_r, stop_task_nxt;
  logic [TASK_W-1:0]    disp_task_r, disp_task_nxt;
  logic [1:0]           disp_act_r,  disp_act_nxt;
  logic [TASK_W-1:0]    rej_task_r,  rej_task_nxt;

  logic             accept;
  logic             in_rng;
  logic [IDX_W-1:0] in_idx;
  logic [IDX_W-1:0] pop_idx;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_rng   = (32'(in_item.task_id) < MAX_TASKS);
  assign in_idx   = IDX_W'(in_item.task_id);
  assign pop_idx  = IDX_W'(fifo_stat.pop_slot);

  // Sequencer: event decode, then one pop and one liveness check per queue entry.
  always_comb begin
    state_nxt     = state_r;
    alive_nxt     = alive_r;
    ns_nxt        = ns_r;
    run_task_nxt  = run_task_r;
    run_valid_nxt = run_valid_r;
    ticks_nxt     = ticks_r;
    stop_pend_nxt = stop_pend_r;
    found_nxt     = found_r;
    have_pop_nxt  = have_pop_r;
    stop_task_nxt = stop_task_r;
    disp_task_nxt = disp_task_r;
    disp_act_nxt  = disp_act_r;
    rej_task_nxt  = rej_task_r;
    fifo_cmd      = '0;
    res_valid     = 1'b0;
    res_item      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_item.mode)
            MODE_ADMIT: begin
              if (!in_rng || fifo_stat.full) begin
                rej_task_nxt = in_item.task_id;
                state_nxt    = S_REJ;
              end else begin
                alive_nxt[in_idx]  = 1'b1;
                ns_nxt[in_idx]     = 1'b1;
                fifo_cmd.push      = 1'b1;
                fifo_cmd.push_slot = in_item.task_id;
              end
            end
            MODE_TICK: begin
              stop_pend_nxt = 1'b0;
              found_nxt     = 1'b0;
              have_pop_nxt  = 1'b0;
              state_nxt     = S_POP;
              if (run_valid_r && alive_r[run_task_r]) begin
                if (ticks_r > QT_W'(1)) begin
                  ticks_nxt = ticks_r - 1'b1;
                  state_nxt = S_IDLE;
                end else begin
                  // Quantum used up: stop and requeue, popping first if the queue is full.
                  stop_pend_nxt      = 1'b1;
                  stop_task_nxt      = TASK_W'(run_task_r);
                  fifo_cmd.push      = 1'b1;
                  fifo_cmd.push_slot = TASK_W'(run_task_r);
                  if (fifo_stat.full) begin
                    fifo_cmd.pop = 1'b1;
                    have_pop_nxt = 1'b1;
                  end
                  run_valid_nxt = 1'b0;
                end
              end else begin
                run_valid_nxt = 1'b0;
              end
            end
            MODE_EXIT: begin
              if (in_rng) begin
                alive_nxt[in_idx] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_POP: begin
        if (have_pop_r) begin
          have_pop_nxt = 1'b0;
          state_nxt    = S_CHECK;
        end else if (!fifo_stat.empty) begin
          fifo_cmd.pop = 1'b1;
          state_nxt    = S_CHECK;
        end else begin
          state_nxt = stop_pend_r ? S_STOP : S_IDLE;
        end
      end

      S_CHECK: begin
        if (alive_r[pop_idx]) begin
          run_task_nxt    = pop_idx;
          run_valid_nxt   = 1'b1;
          ticks_nxt       = quantum;
          disp_act_nxt    = ns_r[pop_idx] ? ACT_FIRST : ACT_RESUME;
          ns_nxt[pop_idx] = 1'b0;
          disp_task_nxt   = fifo_stat.pop_slot;
          found_nxt       = 1'b1;
          state_nxt       = stop_pend_r ? S_STOP : S_DISP;
        end else begin
          state_nxt = S_POP;
        end
      end

      S_STOP: begin
        res_valid            = 1'b1;
        res_item.action      = ACT_STOP;
        res_item.target_task = stop_task_r;
        res_item.last        = !found_r;
        if (res_ready) begin
          state_nxt = found_r ? S_DISP : S_IDLE;
        end
      end

      S_DISP: begin
        res_valid            = 1'b1;
        res_item.action      = disp_act_r;
        res_item.target_task = disp_task_r;
        res_item.last        = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      S_REJ: begin
        res_valid            = 1'b1;
        res_item.action      = ACT_REJECT;
        res_item.target_task = rej_task_r;
        res_item.last        = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      alive_r     <= '0;
      ns_r        <= '0;
      run_task_r  <= '0;
      run_valid_r <= 1'b0;
      ticks_r     <= '0;
      stop_pend_r <= 1'b0;
      found_r     <= 1'b0;
      have_pop_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      alive_r     <= alive_nxt;
      ns_r        <= ns_nxt;
      run_task_r  <= run_task_nxt;
      run_valid_r <= run_valid_nxt;
      ticks_r     <= ticks_nxt;
      stop_pend_r <= stop_pend_nxt;
      found_r     <= found_nxt;
      have_pop_r  <= have_pop_nxt;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk) begin
    stop_task_r <= stop_task_nxt;
    disp_task_r <= disp_task_nxt;
    disp_act_r  <= disp_act_nxt;
    rej_task_r  <= rej_task_nxt;
  end

  // No result is offered while a new event can be taken.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !res_valid)
    else $error("result offered while idle");

  // A dispatch always names the task now recorded as running.
  a_disp_running: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && (res_item.action == ACT_FIRST || res_item.action == ACT_RESUME))
      |-> (run_valid_r && (TASK_W'(run_task_r) == res_item.target_task)))
    else $error("dispatch does not match running task");

endmodule

### src/round_robin_quantum_scheduler_top.sv
// Top level of the round-robin time-slice scheduler: ready queue, sequencer, quantum register and result register.
// Admit and exit leave the sequencer idle; a rejected admit gives one reject beat.
// A tick that only counts down also leaves it idle; any other examines queue entries one by one
// (a pop and a liveness check through the ready-queue RAM's single read port) until a live one
// is found or the queue runs dry, and offers its beats; then the next event can be taken.
// Synchronous active-low reset empties the queue, clears all task flags and sets the quantum to 1.
module round_robin_quantum_scheduler_top
  import rrqs_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_item,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [QT_W-1:0] cfg_data
);

  logic [QT_W-1:0] quantum_r;
  logic            out_valid_r;
  out_item_t       out_item_r;
  fifo_cmd_t       fifo_cmd;
  fifo_stat_t      fifo_stat;
  logic            res_valid;
  logic            res_ready;
  out_item_t       res_item;

  // Quantum register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QT_W'(1);
    end else if (cfg_valid) begin
      quantum_r <= cfg_data;
    end
  end

  rrqs_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (fifo_cmd),
    .stat  (fifo_stat)
  );

  rrqs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .quantum   (quantum_r),
    .fifo_cmd  (fifo_cmd),
    .fifo_stat (fifo_stat),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_item  (res_item)
  );

  // Output register: a new beat loads when the register is empty or being drained.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### test/tb_round_robin_quantum_scheduler_top.sv
// Self-checking testbench of the round-robin time-slice scheduler top level.
`timescale 1ns / 100ps

module tb_round_robin_quantum_scheduler_top;
  import rrqs_pkg::*;

  // Event code that the block ignores.
  localparam logic [1:0] MODE_NONE = 2'd3;

  // Share of cycles, in percent, in which each side idles.
  localparam int IDLE_PCT = 38;

  // Quiet cycles after the last result before a register write or the end.
  localparam int SETTLE_CYCLES = 300;

  // Cycle limit of the whole run.
  localparam int CYCLE_LIMIT = 1000000;

  // Clock, reset and block ports.
  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  in_item_t        in_item   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_item_t       out_item;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [QT_W-1:0] cfg_data  = '0;

  // Events waiting for the driver and result beats waiting for the block.
  in_item_t  pending_events[$];
  out_item_t expected_beats[$];

  // Scheduler state as the testbench sees it.
  logic [QT_W-1:0]   quantum;
  logic [TASK_W-1:0] ready_q[$];
  bit                alive_mask[MAX_TASKS];
  bit                fresh_mask[MAX_TASKS];
  logic [TASK_W-1:0] run_task;
  bit                run_valid;
  logic [QT_W-1:0]   ticks_left;

  // Run bookkeeping.
  int cycles     = 0;
  int errors     = 0;
  bit in_taken   = 1'b0;
  bit calm       = 1'b0;

  round_robin_quantum_scheduler_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // Free-running clock with a 2 ns period.
  always #1 clk = ~clk;

  // Builds one result beat; the last flag is set by the caller.
  function automatic out_item_t make_beat(logic [1:0] action, logic [TASK_W-1:0] target);
    out_item_t beat;
    beat.action      = action;
    beat.target_task = target;
    beat.last        = 1'b0;
    return beat;
  endfunction

  // Applies one accepted event to the scheduler state and queues the beats it causes.
  function automatic void schedule_event(in_item_t ev);
    out_item_t         beat[2];
    int                n;
    bit                held;
    bit                found;
    logic [TASK_W-1:0] held_slot;
    logic [TASK_W-1:0] slot;
    n    = 0;
    held = 1'b0;
    case (ev.mode)
      MODE_ADMIT: begin
        if (ready_q.size() >= MAX_TASKS) begin
          beat[n] = make_beat(ACT_REJECT, ev.task_id);
          n++;
        end else begin
          alive_mask[ev.task_id] = 1'b1;
          fresh_mask[ev.task_id] = 1'b1;
          ready_q.push_back(ev.task_id);
        end
      end
      MODE_EXIT: begin
        alive_mask[ev.task_id] = 1'b0;
      end
      MODE_TICK: begin
        if (run_valid && alive_mask[run_task] && ticks_left > 1) begin
          // Quantum still running: count it down.
          ticks_left = ticks_left - 1'b1;
        end else begin
          // Stop and requeue a live running task; a dead one is dropped quietly.
          if (run_valid && alive_mask[run_task]) begin
            beat[n] = make_beat(ACT_STOP, run_task);
            n++;
            if (ready_q.size() >= MAX_TASKS) begin
              held_slot = ready_q.pop_front();
              held      = 1'b1;
            end
            ready_q.push_back(run_task);
          end
          run_valid = 1'b0;
          // Pop entries until a live task is found and dispatch it.
          found = 1'b0;
          while (!found && (held || ready_q.size() > 0)) begin
            if (held) begin
              slot = held_slot;
              held = 1'b0;
            end else begin
              slot = ready_q.pop_front();
            end
            if (alive_mask[slot]) begin
              found      = 1'b1;
              run_task   = slot;
              run_valid  = 1'b1;
              ticks_left = quantum;
              beat[n]    = make_beat(fresh_mask[slot] ? ACT_FIRST : ACT_RESUME, slot);
              n++;
              fresh_mask[slot] = 1'b0;
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (n > 0) begin
      beat[n-1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      expected_beats.push_back(beat[i]);
    end
  endfunction

  // Reports one field that differs from its expected value.
  task automatic report_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // Monitor: cycle limit, result checking and prediction of accepted events.
  always @(posedge clk) begin
    out_item_t exp_beat;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      in_taken = rst_n && in_valid && in_ready;
      if (rst_n && out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat: action %0d, target_task %0d, last %0d",
                 out_item.action, out_item.target_task, out_item.last);
          errors++;
        end else begin
          exp_beat = expected_beats.pop_front();
          report_field("action", 8'(exp_beat.action), 8'(out_item.action));
          report_field("target_task", 8'(exp_beat.target_task), 8'(out_item.target_task));
          report_field("last", 8'(exp_beat.last), 8'(out_item.last));
        end
      end
      if (in_taken) begin
        schedule_event(in_item);
      end
    end
  end

  // Driver: offers the next pending event, idling at random between beats.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_events.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_item  <= pending_events.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side stalls at random, except during the calm stretch.
  always @(negedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Queues one event for the driver.
  task automatic add_event(logic [1:0] mode, logic [TASK_W-1:0] id);
    in_item_t ev;
    ev.mode    = mode;
    ev.task_id = id;
    pending_events.push_back(ev);
  endtask

  // Queues random traffic in bursts: admit floods, tick runs, exit bursts and noise.
  task automatic add_random_events(int count, int quantum_len);
    int         kind;
    int         len;
    int         roll;
    logic [1:0] mode;
    while (count > 0) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        len = $urandom_range(70, 4);
      end else if (kind < 65) begin
        len = $urandom_range(2 * quantum_len + 6, 1);
      end else if (kind < 85) begin
        len = $urandom_range(30, 3);
      end else begin
        len = $urandom_range(20, 5);
      end
      for (int i = 0; i < len && count > 0; i++) begin
        roll = $urandom_range(99);
        if (kind < 25) begin
          mode = (roll < 90) ? MODE_ADMIT : MODE_TICK;
        end else if (kind < 65) begin
          mode = (roll < 85) ? MODE_TICK : (roll < 95) ? MODE_EXIT : MODE_ADMIT;
        end else if (kind < 85) begin
          mode = (roll < 70) ? MODE_EXIT : MODE_TICK;
        end else begin
          mode = 2'($urandom_range(3));
        end
        add_event(mode, TASK_W'($urandom_range(MAX_TASKS - 1)));
        // Ignored events do not count towards the total.
        if (mode != MODE_NONE) begin
          count--;
        end
      end
    end
  endtask

  // Waits until every event is taken and every beat has arrived, then settles.
  task automatic wait_idle();
    do begin
      @(negedge clk);
    end while (pending_events.size() > 0 || (in_valid && !in_taken) ||
               expected_beats.size() > 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes the quantum register through its own channel.
  task automatic write_quantum(logic [QT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    quantum = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stimulus sequence.
  initial begin
    logic [QT_W-1:0] phase_quanta[6];
    phase_quanta = '{6'd0, 6'd50, 6'd63, 6'd2, 6'd1, 6'd1};
    phase_quanta[5] = QT_W'($urandom_range(50, 1));

    // Reset state of the scheduler.
    quantum    = 6'd1;
    run_task   = '0;
    run_valid  = 1'b0;
    ticks_left = '0;
    foreach (alive_mask[i]) begin
      alive_mask[i] = 1'b0;
      fresh_mask[i] = 1'b0;
    end

    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed events at the reset quantum of one.
    add_event(MODE_TICK, 6'd0);    // tick with nothing to run
    add_event(MODE_EXIT, 6'd5);    // exit of an unknown slot
    add_event(MODE_NONE, 6'd9);    // ignored event code
    add_event(MODE_ADMIT, 6'd0);
    add_event(MODE_TICK, 6'd0);    // first start of slot 0
    add_event(MODE_TICK, 6'd63);   // only task: stop then resume
    add_event(MODE_ADMIT, 6'd63);
    add_event(MODE_TICK, 6'd0);    // stop 0, first start 63
    add_event(MODE_EXIT, 6'd63);
    add_event(MODE_TICK, 6'd0);    // dead running task dropped, resume 0
    add_event(MODE_ADMIT, 6'd0);   // second entry for a live slot
    add_event(MODE_TICK, 6'd0);    // stop 0, first start 0 again
    add_event(MODE_TICK, 6'd0);
    add_event(MODE_EXIT, 6'd0);
    add_event(MODE_TICK, 6'd0);    // nothing live left to dispatch
    add_event(MODE_ADMIT, 6'd42);
    add_event(MODE_EXIT, 6'd42);
    add_event(MODE_TICK, 6'd0);    // only a dead entry in the queue
    add_event(MODE_ADMIT, 6'd21);
    add_event(MODE_EXIT, 6'd21);
    add_event(MODE_ADMIT, 6'd21);  // re-admitted after exit
    add_event(MODE_TICK, 6'd0);
    add_event(MODE_EXIT, 6'd63);   // exit of a slot that is already dead
    add_event(MODE_TICK, 6'd0);
    add_random_events(200, 1);
    wait_idle();

    // Random phases, each under its own quantum; one of them never idles.
    for (int p = 0; p < 6; p++) begin
      write_quantum(phase_quanta[p]);
      calm = (p == 3);
      add_random_events(240, (phase_quanta[p] == 0) ? 1 : phase_quanta[p]);
      wait_idle();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
src/rrqs_pkg.sv
src/rrqs_ram.sv
src/rrqs_fifo.sv
src/rrqs_ctrl.sv
src/round_robin_quantum_scheduler_top.sv
test/tb_round_robin_quantum_scheduler_top.sv
